// ===== design/perl_pkg.sv =====
// Shared types, constants and the gradient table function of the 2D gradient noise block.
`default_nettype none

package perl_pkg;

   localparam int unsigned FRAC_BITS_DEF  = 16;
   localparam int unsigned ANGLE_BITS_DEF = 10;
   localparam int unsigned QUEUE_DEPTH    = 4;
   localparam int unsigned CSR_ADDR_W     = 3;

   localparam logic [31:0] HASH_K1       = 32'h68e31da4;
   localparam logic [31:0] HASH_K2       = 32'hb5297a4d;
   localparam logic [31:0] HASH_K3       = 32'h1b56c4e9;
   localparam logic [31:0] LATTICE_PRIME = 32'd198491317;

   // Word index of the seed register (byte address bit 2).
   localparam logic CSR_IDX_SEED = 1'b0;

   typedef struct packed {
      logic [31:0] x0;
      logic [31:0] y0;
      logic [15:0] tx;
      logic [15:0] ty;
   } point_type;

   function automatic logic [14:0] q30_to_q15(input logic signed [63:0] v);
      logic signed [63:0] c;
      logic [63:0] u;
      c = v;
      if (c < 0) c = 0;
      if (c > 64'sd1073741824) c = 64'sd1073741824;
      u = (64'(c) + 64'd16384) >> 15;
      if (u > 64'd32767) u = 64'd32767;
      return u[14:0];
   endfunction

   // Cosine in [29:15] and sine in [14:0] for step r of the first quadrant.
   function automatic logic [29:0] grad_entry(input int unsigned ab, input int unsigned r);
      logic [63:0] th;
      logic [63:0] th2;
      logic [63:0] term;
      logic signed [63:0] sn;
      logic signed [63:0] cs;
      th   = (64'(r) * 64'd1686629713) >> (ab - 2);
      th2  = (th * th) >> 30;
      sn   = $signed(th);
      term = th;
      term = ((term * th2) >> 30) / 64'd6;   sn = sn - $signed(term);
      term = ((term * th2) >> 30) / 64'd20;  sn = sn + $signed(term);
      term = ((term * th2) >> 30) / 64'd42;  sn = sn - $signed(term);
      term = ((term * th2) >> 30) / 64'd72;  sn = sn + $signed(term);
      term = ((term * th2) >> 30) / 64'd110; sn = sn - $signed(term);
      term = ((term * th2) >> 30) / 64'd156; sn = sn + $signed(term);
      term = ((term * th2) >> 30) / 64'd210; sn = sn - $signed(term);
      cs   = 64'sd1073741824;
      term = 64'd1073741824;
      term = ((term * th2) >> 30) / 64'd2;   cs = cs - $signed(term);
      term = ((term * th2) >> 30) / 64'd12;  cs = cs + $signed(term);
      term = ((term * th2) >> 30) / 64'd30;  cs = cs - $signed(term);
      term = ((term * th2) >> 30) / 64'd56;  cs = cs + $signed(term);
      term = ((term * th2) >> 30) / 64'd90;  cs = cs - $signed(term);
      term = ((term * th2) >> 30) / 64'd132; cs = cs + $signed(term);
      term = ((term * th2) >> 30) / 64'd182; cs = cs - $signed(term);
      return {q30_to_q15(cs), q30_to_q15(sn)};
   endfunction

endpackage

`default_nettype wire

// ===== design/perl_front.sv =====
// Front end: request intake, lattice cell and fraction split, and the seed register.
`default_nettype none

module perl_front import perl_pkg::*; #(
   parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic signed [31:0]    req_point_x,
   input  wire logic signed [31:0]    req_point_y,
   input  wire logic                  q_full,
   output logic                       q_push,
   output point_type                  q_data,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]           pwdata,
   output logic [31:0]                prdata,
   output logic                       pready,
   output logic [31:0]                seed
);

   logic [31:0] seed_ff;
   logic [31:0] seed_in;
   logic [15:0] tx;
   logic [15:0] ty;

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   generate
      if (FRAC_BITS >= 16) begin : g_frac_trunc
         assign tx = req_point_x[FRAC_BITS-1 -: 16];
         assign ty = req_point_y[FRAC_BITS-1 -: 16];
      end else begin : g_frac_pad
         assign tx = {req_point_x[FRAC_BITS-1:0], {(16-FRAC_BITS){1'b0}}};
         assign ty = {req_point_y[FRAC_BITS-1:0], {(16-FRAC_BITS){1'b0}}};
      end
   endgenerate

   always_comb begin
      q_data.x0 = 32'(req_point_x >>> FRAC_BITS);
      q_data.y0 = 32'(req_point_y >>> FRAC_BITS);
      q_data.tx = tx;
      q_data.ty = ty;
   end

   always_comb begin
      seed_in = seed_ff;
      if (psel && penable && pwrite && (paddr[2] == CSR_IDX_SEED)) seed_in = pwdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
      end else begin
         seed_ff <= seed_in;
      end
   end

   assign prdata = (paddr[2] == CSR_IDX_SEED) ? seed_ff : '0;
   assign pready = 1'b1;
   assign seed   = seed_ff;

endmodule

`default_nettype wire

// ===== design/perl_queue.sv =====
// Short request queue between the front end and the arithmetic back end.
`default_nettype none

module perl_queue import perl_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire point_type  push_data,
   output logic            full,
   input  wire logic       pop,
   output point_type       pop_data,
   output logic            not_empty
);

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

   point_type        slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [PTR_W:0]   count_ff;
   logic [PTR_W:0]   count_in;

   assign full      = (count_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_data;
   end

endmodule

`default_nettype wire

// ===== design/perl_back.sv =====
// Back end: corner hash, gradient table, dot products, smootherstep weights and lerps.
`default_nettype none

module perl_back import perl_pkg::*; #(
   parameter int unsigned ANGLE_BITS = ANGLE_BITS_DEF
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire point_type       q_data,
   input  wire logic            q_valid,
   output logic                 q_pop,
   input  wire logic [31:0]     seed,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output logic signed [15:0]   rsp_noise_value
);

   localparam int unsigned ROM_AW    = ANGLE_BITS - 2;
   localparam int unsigned ROM_DEPTH = 2 ** ROM_AW;

   logic [29:0] grad_rom [ROM_DEPTH];

   generate
      for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_rom
         assign grad_rom[g] = grad_entry(ANGLE_BITS, g);
      end
   endgenerate

   function automatic logic [31:0] hash_mid(input logic [31:0] m, input logic [31:0] s);
      logic [31:0] a;
      a = m + s;
      a = a ^ (a >> 8);
      return a * HASH_K2;
   endfunction

   function automatic logic [31:0] hash_late(input logic [31:0] m);
      logic [31:0] b;
      b = m ^ (m << 8);
      return b * HASH_K3;
   endfunction

   function automatic logic [16:0] cap_weight(input logic [35:0] prod);
      logic [35:0] s;
      s = prod >> 16;
      return (s > 36'd65536) ? 17'd65536 : s[16:0];
   endfunction

   // Quadrant rotation of the first-quadrant pair: gx in [31:16], gy in [15:0].
   function automatic logic [31:0] rotate(input logic [29:0] e, input logic [1:0] q);
      logic signed [15:0] c;
      logic signed [15:0] s;
      logic [31:0] r;
      c = signed'({1'b0, e[29:15]});
      s = signed'({1'b0, e[14:0]});
      case (q)
         2'd0: begin
            r = {c, s};
         end
         2'd1: begin
            r = {-s, c};
         end
         2'd2: begin
            r = {-c, -s};
         end
         default: begin
            r = {s, -c};
         end
      endcase
      return r;
   endfunction

   logic en;
   logic [11:1] vld_ff;
   logic        rsp_valid_ff;
   logic signed [15:0] noise_ff;
   logic signed [15:0] noise_in;

   // Stage 1
   logic [31:0] x0_ff, x1_ff, ym_ff;
   logic [15:0] t2x_ff, t2y_ff;
   // Offsets carried to the dot-product stage
   logic [15:0] tx_ff [1:6];
   logic [15:0] ty_ff [1:6];
   // Stage 2
   logic [31:0] idx_ff [4];
   logic [15:0] t3x_ff, t3y_ff;
   logic [19:0] plx_ff, ply_ff;
   // Weights carried to the two lerp levels
   logic [16:0] wx_ff [3:8];
   logic [16:0] wy_ff [3:10];
   // Hash stages
   logic [31:0] m1_ff [4];
   logic [31:0] m2_ff [4];
   logic [31:0] m3_ff [4];
   logic [29:0] ent_ff [4];
   logic [1:0]  quad_ff [4];
   // Dot products
   logic signed [33:0] pgx_ff [4];
   logic signed [33:0] pgy_ff [4];
   logic signed [34:0] n_ff [4];
   // Lerps
   logic signed [53:0] dtop_ff, dbot_ff, dv_ff;
   logic signed [34:0] n00_ff, n01_ff, top_ff, bot_ff, top2_ff;

   logic [31:0] sqx, sqy, cux, cuy;
   logic [31:0] hsh [4];
   logic [31:0] rot [4];
   logic signed [17:0] dx [4];
   logic signed [17:0] dy [4];
   logic signed [35:0] v_sum;
   logic signed [19:0] r_val;

   assign en    = !(rsp_valid_ff && rsp_stall);
   assign q_pop = en && q_valid;

   always_comb begin
      sqx = 32'(q_data.tx) * 32'(q_data.tx);
      sqy = 32'(q_data.ty) * 32'(q_data.ty);
      cux = 32'(t2x_ff) * 32'(tx_ff[1]);
      cuy = 32'(t2y_ff) * 32'(ty_ff[1]);
      for (int i = 0; i < 4; i++) begin
         hsh[i] = m3_ff[i] ^ (m3_ff[i] >> 8);
         rot[i] = rotate(ent_ff[i], quad_ff[i]);
      end
      // Corner order: (x0,y0), (x1,y0), (x0,y1), (x1,y1); t-1 is {2'b11, t}.
      dx[0] = signed'({2'b00, tx_ff[6]});
      dx[1] = signed'({2'b11, tx_ff[6]});
      dx[2] = dx[0];
      dx[3] = dx[1];
      dy[0] = signed'({2'b00, ty_ff[6]});
      dy[1] = dy[0];
      dy[2] = signed'({2'b11, ty_ff[6]});
      dy[3] = dy[2];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x0_ff     <= q_data.x0;
         x1_ff     <= q_data.x0 + 32'd1;
         ym_ff     <= q_data.y0 * LATTICE_PRIME;
         tx_ff[1]  <= q_data.tx;
         ty_ff[1]  <= q_data.ty;
         t2x_ff    <= sqx[31:16];
         t2y_ff    <= sqy[31:16];
         for (int s = 2; s <= 6; s++) begin
            tx_ff[s] <= tx_ff[s-1];
            ty_ff[s] <= ty_ff[s-1];
         end

         idx_ff[0] <= x0_ff + ym_ff;
         idx_ff[1] <= x1_ff + ym_ff;
         idx_ff[2] <= x0_ff + ym_ff + LATTICE_PRIME;
         idx_ff[3] <= x1_ff + ym_ff + LATTICE_PRIME;
         t3x_ff    <= cux[31:16];
         t3y_ff    <= cuy[31:16];
         plx_ff    <= 20'(t2x_ff) * 20'd6 + 20'd655360 - 20'(tx_ff[1]) * 20'd15;
         ply_ff    <= 20'(t2y_ff) * 20'd6 + 20'd655360 - 20'(ty_ff[1]) * 20'd15;

         wx_ff[3]  <= cap_weight(36'(t3x_ff) * 36'(plx_ff));
         wy_ff[3]  <= cap_weight(36'(t3y_ff) * 36'(ply_ff));
         for (int s = 4; s <= 8; s++) wx_ff[s] <= wx_ff[s-1];
         for (int s = 4; s <= 10; s++) wy_ff[s] <= wy_ff[s-1];

         for (int i = 0; i < 4; i++) begin
            m1_ff[i]   <= idx_ff[i] * HASH_K1;
            m2_ff[i]   <= hash_mid(m1_ff[i], seed);
            m3_ff[i]   <= hash_late(m2_ff[i]);
            quad_ff[i] <= hsh[i][31:30];
            ent_ff[i]  <= grad_rom[hsh[i][29 -: ROM_AW]];
            pgx_ff[i]  <= signed'(rot[i][31:16]) * dx[i];
            pgy_ff[i]  <= signed'(rot[i][15:0]) * dy[i];
            n_ff[i]    <= 35'(pgx_ff[i]) + 35'(pgy_ff[i]);
         end

         dtop_ff <= (36'(n_ff[1]) - 36'(n_ff[0])) * signed'({1'b0, wx_ff[8]});
         dbot_ff <= (36'(n_ff[3]) - 36'(n_ff[2])) * signed'({1'b0, wx_ff[8]});
         n00_ff  <= n_ff[0];
         n01_ff  <= n_ff[2];

         top_ff  <= 35'(54'(n00_ff) + (dtop_ff >>> 16));
         bot_ff  <= 35'(54'(n01_ff) + (dbot_ff >>> 16));

         dv_ff   <= (36'(bot_ff) - 36'(top_ff)) * signed'({1'b0, wy_ff[10]});
         top2_ff <= top_ff;

         noise_ff <= noise_in;
      end
   end

   always_comb begin
      v_sum = 36'(35'(54'(top2_ff) + (dv_ff >>> 16))) + 36'sd32768;
      r_val = 20'(v_sum >>> 16);
      if (r_val > 20'sd32767) begin
         noise_in = 16'sd32767;
      end else if (r_val < -20'sd32768) begin
         noise_in = -16'sd32768;
      end else begin
         noise_in = 16'(r_val);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff       <= {vld_ff[10:1], q_pop};
         rsp_valid_ff <= vld_ff[11];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_noise_value = noise_ff;

endmodule

`default_nettype wire

// ===== design/perlin_gradient_noise_2d.sv =====
// Top level of the 2D gradient noise block: front end, request queue and back end.
//
// One point enters per cycle and passes the back end after leaving the four-entry request
// queue, so the block sustains one point per clock unless stalled. The back-end pipeline
// holds as a whole while a result is stalled at the output register; the queue keeps taking
// requests until it is full. The corner hash (three 32x32 multiplies per corner, four corners
// in parallel lanes) sets the depth of the pipeline. The seed register is read and written
// through the APB port at byte address 0 and should only be changed while the block is idle.
`default_nettype none

module perlin_gradient_noise_2d import perl_pkg::*; #(
   parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF,
   parameter int unsigned ANGLE_BITS = ANGLE_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic signed [31:0]    req_point_x,
   input  wire logic signed [31:0]    req_point_y,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic signed [15:0]         rsp_noise_value,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]           pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);

   point_type   push_data;
   point_type   pop_data;
   logic        q_push;
   logic        q_full;
   logic        q_pop;
   logic        q_not_empty;
   logic [31:0] seed;

   perl_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_point_x (req_point_x),
      .req_point_y (req_point_y),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_data      (push_data),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .seed        (seed)
   );

   perl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (pop_data),
      .not_empty (q_not_empty)
   );

   perl_back #(.ANGLE_BITS(ANGLE_BITS)) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_data          (pop_data),
      .q_valid         (q_not_empty),
      .q_pop           (q_pop),
      .seed            (seed),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_noise_value (rsp_noise_value)
   );

endmodule

`default_nettype wire

// ===== design/perl_checker.sv =====
// Port-level checks of the 2D gradient noise block, bound to its top level.
`default_nettype none

module perl_checker import perl_pkg::*; (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_stall,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_stall,
   input wire logic signed [15:0]    rsp_noise_value,
   input wire logic                  psel,
   input wire logic                  penable,
   input wire logic                  pwrite,
   input wire logic [CSR_ADDR_W-1:0] paddr,
   input wire logic [31:0]           pwdata,
   input wire logic [31:0]           prdata,
   input wire logic                  pready
);

   // A result that is held back keeps its value until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_noise_value))
      else $error("stalled result changed or vanished");

   a_pready: assert property (@(posedge clock) pready)
      else $error("pready dropped");

   // No result can be pending in the cycle after reset.
   a_reset_clear: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid straight after reset");

   // The request queue is empty after reset, so requests are taken at once.
   a_reset_ready: assert property (@(posedge clock) reset |=> !req_stall)
      else $error("request stalled straight after reset");

   // A completed seed write reads back on the next cycle.
   a_seed_readback: assert property (@(posedge clock) disable iff (reset)
      psel && penable && pwrite && pready && (paddr == '0) |=>
         (paddr != '0) || (prdata == $past(pwdata)))
      else $error("seed register did not read back the written value");

endmodule

bind perlin_gradient_noise_2d perl_checker u_perl_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_noise_value (rsp_noise_value),
   .psel            (psel),
   .penable         (penable),
   .pwrite          (pwrite),
   .paddr           (paddr),
   .pwdata          (pwdata),
   .prdata          (prdata),
   .pready          (pready)
);

`default_nettype wire

// ===== bench/tb_perlin_gradient_noise_2d.sv =====
// Self-checking testbench for the 2D gradient noise block with a bit-exact noise predictor.
`default_nettype none

module tb_perlin_gradient_noise_2d import perl_pkg::*;;

   localparam int unsigned FB = FRAC_BITS_DEF;
   localparam int unsigned AB = ANGLE_BITS_DEF;
   localparam logic [CSR_ADDR_W-1:0] SEED_ADDR = CSR_ADDR_W'(CSR_IDX_SEED) << 2;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic signed [31:0] req_point_x;
   logic signed [31:0] req_point_y;
   logic rsp_valid;
   logic rsp_stall;
   logic signed [15:0] rsp_noise_value;
   logic psel, penable, pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic pready;

   perlin_gradient_noise_2d DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_point_x(req_point_x), .req_point_y(req_point_y),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_noise_value(rsp_noise_value),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   logic [31:0] seed_value;
   logic signed [15:0] noise_expected[$];
   int errors;
   int noise_checked;
   int send_idle_pct;
   int recv_idle_pct;

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // Q30 to Q15 with clamp, round half up and saturation.
   function automatic longint to_q15(input longint v);
      longint u;
      if (v < 0) v = 0;
      if (v > 64'sd1073741824) v = 64'sd1073741824;
      u = (v + 16384) >>> 15;
      if (u > 32767) u = 32767;
      return u;
   endfunction

   function automatic void unit_gradient(input logic [31:0] k, output longint gx,
                                         output longint gy);
      logic [1:0] quad;
      logic [63:0] r, th, th2, term;
      longint sn, cs, s, c;
      quad = k[AB-1 -: 2];
      r = 64'(k & ((32'd1 << (AB - 2)) - 1));
      th = (r * 64'd1686629713) >> (AB - 2);
      th2 = (th * th) >> 30;
      term = th;
      sn = longint'(th);
      for (int n = 3; n <= 15; n += 2) begin
         term = ((term * th2) >> 30) / 64'((n - 1) * n);
         if (((n - 1) / 2) % 2 == 1) sn -= longint'(term);
         else sn += longint'(term);
      end
      term = 64'd1073741824;
      cs = 64'sd1073741824;
      for (int n = 2; n <= 14; n += 2) begin
         term = ((term * th2) >> 30) / 64'((n - 1) * n);
         if ((n / 2) % 2 == 1) cs -= longint'(term);
         else cs += longint'(term);
      end
      s = to_q15(sn);
      c = to_q15(cs);
      case (quad)
         2'd0: begin gx = c; gy = s; end
         2'd1: begin gx = -s; gy = c; end
         2'd2: begin gx = -c; gy = -s; end
         default: begin gx = s; gy = -c; end
      endcase
   endfunction

   function automatic longint corner_dot(input logic [31:0] cx, input logic [31:0] cy,
                                         input longint dx, input longint dy);
      logic [31:0] h;
      longint gx, gy;
      h = cx + LATTICE_PRIME * cy;
      h = h * HASH_K1;
      h = h + seed_value;
      h = h ^ (h >> 8);
      h = h * HASH_K2;
      h = h ^ (h << 8);
      h = h * HASH_K3;
      h = h ^ (h >> 8);
      unit_gradient(h >> (32 - AB), gx, gy);
      return gx * dx + gy * dy;
   endfunction

   function automatic longint smootherstep(input longint t);
      longint t2, t3, p, s;
      t2 = (t * t) >>> 16;
      t3 = (t2 * t) >>> 16;
      p = 6 * t2 - 15 * t + 10 * 65536;
      if (p < 0) p = 0;
      s = (t3 * p) >>> 16;
      if (s > 65536) s = 65536;
      return s;
   endfunction

   // Arithmetic shift right is a floor for signed values.
   function automatic longint blend(input longint a, input longint b, input longint w);
      return a + (((b - a) * w) >>> 16);
   endfunction

   function automatic logic signed [15:0] predict_noise(input logic [31:0] px,
                                                        input logic [31:0] py);
      logic [31:0] x0, y0;
      longint tx, ty, wx, wy, n00, n10, n01, n11, v, r;
      x0 = 32'($signed(px) >>> FB);
      y0 = 32'($signed(py) >>> FB);
      tx = longint'(px & ((32'd1 << FB) - 1));
      ty = longint'(py & ((32'd1 << FB) - 1));
      if (FB >= 16) begin
         tx = tx >> (FB - 16);
         ty = ty >> (FB - 16);
      end else begin
         tx = tx << (16 - FB);
         ty = ty << (16 - FB);
      end
      wx = smootherstep(tx);
      wy = smootherstep(ty);
      n00 = corner_dot(x0, y0, tx, ty);
      n10 = corner_dot(x0 + 1, y0, tx - 65536, ty);
      n01 = corner_dot(x0, y0 + 1, tx, ty - 65536);
      n11 = corner_dot(x0 + 1, y0 + 1, tx - 65536, ty - 65536);
      v = blend(blend(n00, n10, wx), blend(n01, n11, wx), wy);
      r = (v + 32768) >>> 16;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return 16'(r);
   endfunction

   // The request stays up after acceptance so that the next one can follow at once;
   // it is dropped by an idle cycle or by drain_results.
   task automatic send_point(input logic [31:0] px, input logic [31:0] py);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_point_x <= px;
      req_point_y <= py;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      noise_expected.push_back(predict_noise(px, py));
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (noise_expected.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_seed(input logic [31:0] value);
      drain_results();
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= SEED_ADDR; pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      seed_value = value;
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      @(negedge clock);
      psel <= 1'b1;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata !== value) begin
         $display("%0t seed read back: expected %h actual %h", $time, value, prdata);
         errors++;
      end
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0;
   endtask

   function automatic logic [31:0] random_coord();
      case ($urandom_range(3))
         0: return $urandom();
         1: return 32'($signed($urandom_range(2047)) - 1024) << FB | $urandom_range(65535);
         2: return {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom())};
         default: return {$urandom_range(1) ? 16'h7fff : 16'h8000, 16'($urandom())};
      endcase
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (noise_expected.size() == 0) begin
            $display("%0t unexpected noise value %0d", $time, rsp_noise_value);
            errors++;
         end else begin
            logic signed [15:0] want;
            want = noise_expected.pop_front();
            noise_checked++;
            if (rsp_noise_value !== want) begin
               $display("%0t noise_value: expected %0d actual %0d",
                        $time, want, rsp_noise_value);
               errors++;
            end
         end
      end
   end

   always @(negedge clock) rsp_stall <= ($urandom_range(99) < recv_idle_pct);

   task automatic test_extremes();
      logic [31:0] edges[8];
      edges = '{32'h0, 32'hffffffff, 32'h7fffffff, 32'h80000000,
                32'h0000ffff, 32'h00010000, 32'h00008000, 32'hffff0000};
      foreach (edges[i]) send_point(edges[i], edges[7 - i]);
      // Lattice index wrap on both axes at the corners x0+1 and y0+1.
      send_point(32'h7fff8000, 32'h7fff4000);
      send_point(32'hffff1234, 32'hffffabcd);
      send_point(32'h12345678, 32'h9abcdef0);
   endtask

   task automatic test_seed_settings();
      write_seed(32'hffffffff);
      send_point(32'h00018000, 32'h00024000);
      send_point(32'h80000000, 32'h7fffffff);
      write_seed(32'h00000001);
      send_point(32'h00018000, 32'h00024000);
      send_point(32'hfffe0001, 32'h0003ffff);
   endtask

   task automatic test_random_points(input int count);
      for (int i = 0; i < count; i++) begin
         if (i % 100 == 99) write_seed($urandom());
         if (i == count / 2) drain_results();
         send_point(random_coord(), random_coord());
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0; req_point_x = '0; req_point_y = '0;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      seed_value = '0;
      errors = 0;
      noise_checked = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (7) @(negedge clock);
      reset = 1'b0;
      test_extremes();
      test_seed_settings();
      write_seed(32'h0);
      send_idle_pct = 33; recv_idle_pct = 56;
      test_random_points(510);
      send_idle_pct = 56; recv_idle_pct = 33;
      test_random_points(510);
      send_idle_pct = 0; recv_idle_pct = 0;
      test_random_points(510);
      drain_results();
      $display("Checked %0d noise values over edge coordinates, lattice wrap and random points,",
               noise_checked);
      $display("with seed changes including all zeros and all ones, under varied stalls.");
      if (errors == 0) $display("tb_perlin_gradient_noise_2d passed");
      else $display("tb_perlin_gradient_noise_2d failed");
      $finish;
   end

   initial begin
      #(12 * 400000);
      $display("tb_perlin_gradient_noise_2d failed");
      $finish;
   end

endmodule

`default_nettype wire
